>>> rtl/rpds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpds_pkg
// Shared types, field widths and constants of the ridge point duplicate
// suppression block.
// ----------------------------------------------------------------------------
package rpds_pkg;

  // field widths
  localparam int STATE_W   = 2;
  localparam int OFS_W     = 11;
  localparam int STR_W     = 16;
  localparam int ROW_W     = 12;
  localparam int OUT_COL_W = 11;
  localparam int FW_W      = 12;
  localparam int FH_W      = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  // geometry
  localparam int MAX_WIDTH_DEF    = 2048;
  localparam int MIN_DIM          = 5;
  localparam int MAX_HEIGHT       = 4096;
  localparam int BORDER           = 2;
  localparam int WIDTH_RST        = 640;
  localparam int HEIGHT_RST       = 480;
  localparam int QUEUE_DEPTH      = 2;

  // closeness test: 25 * d^2 < S^2 is d < 0.2 px with S = 2^frac
  localparam int OFFSET_FRAC_BITS = 10;
  localparam int NEAR_SCALE       = 25;
  localparam int DIFF_W = ((OFFSET_FRAC_BITS + 2 > OFS_W + 1) ?
                           OFFSET_FRAC_BITS + 2 : OFS_W + 1) + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int NEAR_W = SUM_W + 5;
  localparam logic signed [DIFF_W-1:0] OFS_ONE = DIFF_W'(2 ** OFFSET_FRAC_BITS);
  localparam logic [NEAR_W-1:0] NEAR_LIMIT = NEAR_W'(1) << (2 * OFFSET_FRAC_BITS);

  // pixel state codes
  localparam logic [STATE_W-1:0] ST_NONE = 2'd0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // one ridge candidate, as stored in the row buffer
  typedef struct packed {
    logic [STATE_W-1:0]      st;
    logic signed [OFS_W-1:0] ox;
    logic signed [OFS_W-1:0] oy;
    logic [STR_W-1:0]        str;
  } pixel_t;

  // classification of an accepted pixel
  typedef struct packed {
    logic has_out;   // row above exists, a result is due
    logic interior;  // pixel above lies inside the border
    logic col_zero;  // first column, pending pixel comes from the buffer
  } cls_t;

endpackage

>>> rtl/rpds_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpds_if
// Valid/ready channels for candidate pixels in and final states out.
// ----------------------------------------------------------------------------
interface rpds_in_if;
  logic                                valid;
  logic                                ready;
  logic [rpds_pkg::STATE_W-1:0]        pixel_state;
  logic signed [rpds_pkg::OFS_W-1:0]   offset_x;
  logic signed [rpds_pkg::OFS_W-1:0]   offset_y;
  logic [rpds_pkg::STR_W-1:0]          strength;

  modport source (output valid, pixel_state, offset_x, offset_y, strength, input ready);
  modport sink   (input valid, pixel_state, offset_x, offset_y, strength, output ready);
endinterface

interface rpds_out_if;
  logic                               valid;
  logic                               ready;
  logic [rpds_pkg::STATE_W-1:0]       final_state;
  logic [rpds_pkg::ROW_W-1:0]         out_row;
  logic [rpds_pkg::OUT_COL_W-1:0]     out_col;

  modport source (output valid, final_state, out_row, out_col, input ready);
  modport sink   (input valid, final_state, out_row, out_col, output ready);
endinterface

>>> rtl/ridge_point_duplicate_suppress.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ridge_point_duplicate_suppress
// Takes ridge-candidate pixels in raster order and, from the
// second row on, returns for each pixel the final state of the pixel above
// it, after clearing the weaker of any two live points closer than 0.2 px
// (right neighbour checked before the pixel below, ties clear the
// neighbour). Sustained rate is one pixel per clock while the result side
// is ready. The rate is set by the row buffer, one read and one write per
// pixel, and the clearing decision, which depends on the previous pixel's
// decision and is made combinationally. The row buffer needs no clearing
// after reset: the first row of a frame writes every entry before a value
// read from it is used. Frame size writes restart the frame at row 0 and
// must be issued while the block is idle.
// ----------------------------------------------------------------------------
module ridge_point_duplicate_suppress #(
  parameter int MAX_WIDTH = rpds_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rpds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rpds_pkg::CFG_W-1:0]      cfg_wdata_i,
  rpds_in_if.sink                         pix_in,
  rpds_out_if.source                      res_out
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = $bits(rpds_pkg::cls_t) + $bits(rpds_pkg::pixel_t)
                      + rpds_pkg::ROW_W + 2 * CW;

  // front to queue
  logic                       q_push_valid;
  logic                       q_push_ready;
  rpds_pkg::cls_t             push_cls;
  rpds_pkg::pixel_t           push_pix;
  logic [rpds_pkg::ROW_W-1:0] push_row;
  logic [CW-1:0]              push_col;
  logic [CW-1:0]              push_addr;
  logic [QW-1:0]              push_data;

  // queue to back
  logic                       q_pop_valid;
  logic                       q_pop_ready;
  logic [QW-1:0]              pop_data;
  rpds_pkg::cls_t             pop_cls;
  rpds_pkg::pixel_t           pop_pix;
  logic [rpds_pkg::ROW_W-1:0] pop_row;
  logic [CW-1:0]              pop_col;
  logic [CW-1:0]              pop_addr;

  // position tracking and classification
  rpds_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pix_in       (pix_in),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_cls_o   (push_cls),
    .push_pix_o   (push_pix),
    .push_row_o   (push_row),
    .push_col_o   (push_col),
    .push_addr_o  (push_addr)
  );

  assign push_data = {push_cls, push_pix, push_row, push_col, push_addr};

  // decoupling queue
  rpds_queue #(
    .DATA_W (QW),
    .DEPTH  (rpds_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (pop_data)
  );

  assign {pop_cls, pop_pix, pop_row, pop_col, pop_addr} = pop_data;

  // row buffer and suppression pipeline
  rpds_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_cls_i   (pop_cls),
    .pop_pix_i   (pop_pix),
    .pop_row_i   (pop_row),
    .pop_col_i   (pop_col),
    .pop_addr_i  (pop_addr),
    .res_out     (res_out)
  );

  // a cycle in which the result side is ready leaves room for a new pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.ready |=> pix_in.ready)
    else $error("input stalled although the output side was draining");

  // an interior pixel always has a row above it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_valid && q_push_ready && push_cls.interior |-> push_cls.has_out)
    else $error("interior pixel classified in the first row");

endmodule

>>> rtl/rpds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpds_front
// Accepts pixels, tracks the raster position and classifies each pixel for
// the back end. Holds the frame size registers.
// ----------------------------------------------------------------------------
module rpds_front #(
  parameter int MAX_WIDTH = rpds_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rpds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rpds_pkg::CFG_W-1:0]      cfg_wdata_i,
  rpds_in_if.sink                         pix_in,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output rpds_pkg::cls_t                  push_cls_o,
  output rpds_pkg::pixel_t                push_pix_o,
  output logic [rpds_pkg::ROW_W-1:0]      push_row_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    push_col_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    push_addr_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = CW + 1;
  localparam int CMP_W = (WW > rpds_pkg::FW_W) ? WW : rpds_pkg::FW_W;

  logic [rpds_pkg::FW_W-1:0]  width_q;
  logic [rpds_pkg::FH_W-1:0]  height_q;
  logic [CW-1:0]              col_q;
  logic [rpds_pkg::ROW_W-1:0] row_q;

  logic [CMP_W-1:0]           width_ext;
  logic [WW-1:0]              w_lim;
  logic [rpds_pkg::FH_W-1:0]  h_lim;
  logic [WW-1:0]              col_w;
  logic [rpds_pkg::ROW_W-1:0] prev_row;
  logic                       last_col;
  logic                       last_row;
  logic                       accept;

  // saturate the frame size to the supported range
  always_comb begin
    width_ext = CMP_W'(width_q);
    if (width_ext < CMP_W'(rpds_pkg::MIN_DIM)) begin
      w_lim = WW'(rpds_pkg::MIN_DIM);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = WW'(width_ext);
    end
    if (height_q < rpds_pkg::FH_W'(rpds_pkg::MIN_DIM)) begin
      h_lim = rpds_pkg::FH_W'(rpds_pkg::MIN_DIM);
    end else if (height_q > rpds_pkg::FH_W'(rpds_pkg::MAX_HEIGHT)) begin
      h_lim = rpds_pkg::FH_W'(rpds_pkg::MAX_HEIGHT);
    end else begin
      h_lim = height_q;
    end
  end

  // raster position and classification
  always_comb begin
    col_w    = WW'(col_q);
    prev_row = row_q - rpds_pkg::ROW_W'(1);
    last_col = (col_w == w_lim - WW'(1));
    last_row = (rpds_pkg::FH_W'(row_q) == h_lim - rpds_pkg::FH_W'(1));

    push_cls_o.has_out  = (row_q != '0);
    push_cls_o.interior =
      (prev_row >= rpds_pkg::ROW_W'(rpds_pkg::BORDER)) &&
      ((rpds_pkg::FH_W'(prev_row) + rpds_pkg::FH_W'(rpds_pkg::BORDER)) < h_lim) &&
      (col_w >= WW'(rpds_pkg::BORDER)) &&
      ((col_w + WW'(rpds_pkg::BORDER)) < w_lim);
    push_cls_o.col_zero = (col_q == '0);

    push_pix_o.st  = pix_in.pixel_state;
    push_pix_o.ox  = pix_in.offset_x;
    push_pix_o.oy  = pix_in.offset_y;
    push_pix_o.str = pix_in.strength;

    push_row_o  = prev_row;
    push_col_o  = col_q;
    // right neighbour, or column 0 of this row for the next row's first pixel
    push_addr_o = last_col ? '0 : col_q + CW'(1);
  end

  assign pix_in.ready = push_ready_i;
  assign push_valid_o = pix_in.valid;
  assign accept       = pix_in.valid && push_ready_i;

  // frame size registers and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rpds_pkg::FW_W'(rpds_pkg::WIDTH_RST);
      height_q <= rpds_pkg::FH_W'(rpds_pkg::HEIGHT_RST);
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (rpds_pkg::cfg_reg_e'(cfg_idx_i))
        rpds_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_wdata_i[rpds_pkg::FW_W-1:0];
        rpds_pkg::REG_FRAME_HEIGHT: height_q <= cfg_wdata_i[rpds_pkg::FH_W-1:0];
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + rpds_pkg::ROW_W'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

endmodule

>>> rtl/rpds_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpds_queue
// Small FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module rpds_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = rpds_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q;
  logic [PW-1:0]     rd_ptr_q;
  logic [NW-1:0]     count_q;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != NW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + NW'(1);
        2'b01:   count_q <= count_q - NW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/rpds_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpds_back
// Row buffer and suppression pipeline: buffer read, squared distances,
// closeness tests, then the clearing decision and the result register.
// ----------------------------------------------------------------------------
module rpds_back #(
  parameter int MAX_WIDTH = rpds_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pop_valid_i,
  output logic                            pop_ready_o,
  input  rpds_pkg::cls_t                  pop_cls_i,
  input  rpds_pkg::pixel_t                pop_pix_i,
  input  logic [rpds_pkg::ROW_W-1:0]      pop_row_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]    pop_col_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]    pop_addr_i,
  rpds_out_if.source                      res_out
);

  localparam int CW = $clog2(MAX_WIDTH);

  // row buffer, holds the previous row with its final-so-far states
  rpds_pkg::pixel_t row_mem_q [MAX_WIDTH];
  rpds_pkg::pixel_t rd_q;
  rpds_pkg::pixel_t prev_rd_q;

  logic en;
  logic pop;

  // stage 1: buffer data arrives
  logic                       s1_valid_q;
  rpds_pkg::cls_t             s1_cls_q;
  rpds_pkg::pixel_t           s1_cur_q;
  logic [rpds_pkg::ROW_W-1:0] s1_row_q;
  logic [CW-1:0]              s1_col_q;

  // stage 2: squared distances
  logic                       s2_valid_q;
  rpds_pkg::cls_t             s2_cls_q;
  rpds_pkg::pixel_t           s2_cur_q;
  logic [rpds_pkg::ROW_W-1:0] s2_row_q;
  logic [CW-1:0]              s2_col_q;
  logic [rpds_pkg::STATE_W-1:0] s2_pend0_q;
  logic [rpds_pkg::STATE_W-1:0] s2_right_st_q;
  logic [rpds_pkg::SQ_W-1:0]  s2_sq_xr_q;
  logic [rpds_pkg::SQ_W-1:0]  s2_sq_yr_q;
  logic [rpds_pkg::SQ_W-1:0]  s2_sq_xb_q;
  logic [rpds_pkg::SQ_W-1:0]  s2_sq_yb_q;
  logic                       s2_weak_r_q;
  logic                       s2_weak_b_q;

  // stage 3: decision
  logic                       s3_valid_q;
  rpds_pkg::cls_t             s3_cls_q;
  rpds_pkg::pixel_t           s3_cur_q;
  logic [rpds_pkg::ROW_W-1:0] s3_row_q;
  logic [CW-1:0]              s3_col_q;
  logic [rpds_pkg::STATE_W-1:0] s3_pend0_q;
  logic [rpds_pkg::STATE_W-1:0] s3_right_st_q;
  logic                       s3_near_r_q;
  logic                       s3_near_b_q;
  logic                       s3_weak_r_q;
  logic                       s3_weak_b_q;

  // right neighbour state left by the previous pixel
  logic [rpds_pkg::STATE_W-1:0] carry_st_q;

  // result register
  logic                           out_valid_q;
  logic [rpds_pkg::STATE_W-1:0]   out_state_q;
  logic [rpds_pkg::ROW_W-1:0]     out_row_q;
  logic [rpds_pkg::OUT_COL_W-1:0] out_col_q;

  // stage 1 datapath
  logic signed [rpds_pkg::DIFF_W-1:0] dxr;
  logic signed [rpds_pkg::DIFF_W-1:0] dyr;
  logic signed [rpds_pkg::DIFF_W-1:0] dxb;
  logic signed [rpds_pkg::DIFF_W-1:0] dyb;
  logic signed [rpds_pkg::SQ_W-1:0]   dxr_w;
  logic signed [rpds_pkg::SQ_W-1:0]   dyr_w;
  logic signed [rpds_pkg::SQ_W-1:0]   dxb_w;
  logic signed [rpds_pkg::SQ_W-1:0]   dyb_w;

  // stage 2 datapath
  logic [rpds_pkg::SUM_W-1:0]  sum_r;
  logic [rpds_pkg::SUM_W-1:0]  sum_b;
  logic                        near_r;
  logic                        near_b;

  // stage 3 datapath
  logic [rpds_pkg::STATE_W-1:0] pend_st;
  logic [rpds_pkg::STATE_W-1:0] pend_new;
  logic [rpds_pkg::STATE_W-1:0] right_new;
  rpds_pkg::pixel_t             cur_new;

  // the whole pipeline moves unless a result waits
  assign en          = !out_valid_q || res_out.ready;
  assign pop_ready_o = en;
  assign pop         = en && pop_valid_i;

  // position differences against right neighbour and pixel below
  always_comb begin
    dxr = rpds_pkg::DIFF_W'(prev_rd_q.ox) - rpds_pkg::DIFF_W'(rd_q.ox) - rpds_pkg::OFS_ONE;
    dyr = rpds_pkg::DIFF_W'(prev_rd_q.oy) - rpds_pkg::DIFF_W'(rd_q.oy);
    dxb = rpds_pkg::DIFF_W'(prev_rd_q.ox) - rpds_pkg::DIFF_W'(s1_cur_q.ox);
    dyb = rpds_pkg::DIFF_W'(prev_rd_q.oy) - rpds_pkg::DIFF_W'(s1_cur_q.oy)
          - rpds_pkg::OFS_ONE;
    dxr_w = rpds_pkg::SQ_W'(dxr);
    dyr_w = rpds_pkg::SQ_W'(dyr);
    dxb_w = rpds_pkg::SQ_W'(dxb);
    dyb_w = rpds_pkg::SQ_W'(dyb);
  end

  // closeness tests
  always_comb begin
    sum_r  = rpds_pkg::SUM_W'(s2_sq_xr_q) + rpds_pkg::SUM_W'(s2_sq_yr_q);
    sum_b  = rpds_pkg::SUM_W'(s2_sq_xb_q) + rpds_pkg::SUM_W'(s2_sq_yb_q);
    near_r = (rpds_pkg::NEAR_W'(sum_r) * rpds_pkg::NEAR_W'(rpds_pkg::NEAR_SCALE))
             < rpds_pkg::NEAR_LIMIT;
    near_b = (rpds_pkg::NEAR_W'(sum_b) * rpds_pkg::NEAR_W'(rpds_pkg::NEAR_SCALE))
             < rpds_pkg::NEAR_LIMIT;
  end

  // clearing decision: right neighbour first, then the pixel below
  always_comb begin
    pend_st   = s3_cls_q.col_zero ? s3_pend0_q : carry_st_q;
    pend_new  = pend_st;
    right_new = s3_right_st_q;
    cur_new   = s3_cur_q;
    if (s3_cls_q.has_out && s3_cls_q.interior && pend_st != rpds_pkg::ST_NONE) begin
      if (s3_right_st_q != rpds_pkg::ST_NONE && s3_near_r_q) begin
        if (s3_weak_r_q) begin
          pend_new = rpds_pkg::ST_NONE;
        end else begin
          right_new = rpds_pkg::ST_NONE;
        end
      end else if (s3_cur_q.st != rpds_pkg::ST_NONE && s3_near_b_q) begin
        if (s3_weak_b_q) begin
          pend_new = rpds_pkg::ST_NONE;
        end else begin
          cur_new.st = rpds_pkg::ST_NONE;
        end
      end
    end
  end

  // row buffer: read on pop, write the settled current pixel at decision
  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_q <= row_mem_q[pop_addr_i];
    end
    if (en && s3_valid_q) begin
      row_mem_q[s3_col_q] <= cur_new;
    end
  end

  // stage valids, carried state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      carry_st_q  <= rpds_pkg::ST_NONE;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= pop_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q && s3_cls_q.has_out;
      if (s3_valid_q) begin
        carry_st_q <= right_new;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pop) begin
        s1_cls_q <= pop_cls_i;
        s1_cur_q <= pop_pix_i;
        s1_row_q <= pop_row_i;
        s1_col_q <= pop_col_i;
      end
      if (s1_valid_q) begin
        prev_rd_q     <= rd_q;
        s2_cls_q      <= s1_cls_q;
        s2_cur_q      <= s1_cur_q;
        s2_row_q      <= s1_row_q;
        s2_col_q      <= s1_col_q;
        s2_pend0_q    <= prev_rd_q.st;
        s2_right_st_q <= rd_q.st;
        s2_sq_xr_q    <= rpds_pkg::SQ_W'(dxr_w * dxr_w);
        s2_sq_yr_q    <= rpds_pkg::SQ_W'(dyr_w * dyr_w);
        s2_sq_xb_q    <= rpds_pkg::SQ_W'(dxb_w * dxb_w);
        s2_sq_yb_q    <= rpds_pkg::SQ_W'(dyb_w * dyb_w);
        s2_weak_r_q   <= prev_rd_q.str < rd_q.str;
        s2_weak_b_q   <= prev_rd_q.str < s1_cur_q.str;
      end
      if (s2_valid_q) begin
        s3_cls_q      <= s2_cls_q;
        s3_cur_q      <= s2_cur_q;
        s3_row_q      <= s2_row_q;
        s3_col_q      <= s2_col_q;
        s3_pend0_q    <= s2_pend0_q;
        s3_right_st_q <= s2_right_st_q;
        s3_near_r_q   <= near_r;
        s3_near_b_q   <= near_b;
        s3_weak_r_q   <= s2_weak_r_q;
        s3_weak_b_q   <= s2_weak_b_q;
      end
      if (s3_valid_q && s3_cls_q.has_out) begin
        out_state_q <= pend_new;
        out_row_q   <= s3_row_q;
        out_col_q   <= rpds_pkg::OUT_COL_W'(s3_col_q);
      end
    end
  end

  assign res_out.valid       = out_valid_q;
  assign res_out.final_state = out_state_q;
  assign res_out.out_row     = out_row_q;
  assign res_out.out_col     = out_col_q;

endmodule

>>> dv/ridge_point_duplicate_suppress_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ridge_point_duplicate_suppress_tb
// Self-checking bench for the ridge point duplicate suppressor. Pixels are
// streamed in raster order through the input channel. A line-store predictor
// in the bench works out the final state that each pixel from the second row
// on must return for the pixel above it. Returned transactions are compared
// in order, field by field. Frame sizes cover the saturated extremes, random
// small frames and mid-frame restarts. Both channels idle at random, and one
// long output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module ridge_point_duplicate_suppress_tb;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int STUCK_LIMIT   = 3000;
  localparam int RANDOM_PIXELS = 700;
  localparam int WIDE_PIXELS   = 160;
  localparam int ONE_PX        = 1 << rpds_pkg::OFFSET_FRAC_BITS;

  // live pixel state codes driven by the bench
  localparam logic [rpds_pkg::STATE_W-1:0] ST_RIDGE   = 2'd1;
  localparam logic [rpds_pkg::STATE_W-1:0] ST_FLAGGED = 2'd2;
  localparam logic [rpds_pkg::STATE_W-1:0] ST_SPARE   = 2'd3;

  // expected result of one pixel one row above the input
  typedef struct packed {
    logic [rpds_pkg::STATE_W-1:0]   st;
    logic [rpds_pkg::ROW_W-1:0]     row;
    logic [rpds_pkg::OUT_COL_W-1:0] col;
  } final_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [rpds_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [rpds_pkg::CFG_W-1:0]     cfg_wdata_i;

  rpds_in_if  pix_if ();
  rpds_out_if res_if ();

  ridge_point_duplicate_suppress i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_in      (pix_if),
    .res_out     (res_if)
  );

  // clock
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // predictor state: pending line, raster position and frame size
  rpds_pkg::pixel_t line_store [rpds_pkg::MAX_WIDTH_DEF];
  int unsigned      row_cnt;
  int unsigned      col_cnt;
  int unsigned      frame_width_q  = rpds_pkg::WIDTH_RST;
  int unsigned      frame_height_q = rpds_pkg::HEIGHT_RST;
  final_t           final_q [$];

  // idling and bookkeeping
  int gap_max   = 13;
  int stall_max = 13;
  bit hold_req  = 1'b0;
  int n_errors  = 0;
  int n_pixels  = 0;
  int n_checked = 0;
  int n_cleared = 0;
  int n_writes  = 0;
  int n_holds   = 0;
  int stuck_cnt = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < rpds_pkg::MIN_DIM) return rpds_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // closer than 0.2 px, positions shifted by (sx, sy) in offset units
  function automatic bit is_near(rpds_pkg::pixel_t a, rpds_pkg::pixel_t b,
                                 longint sx, longint sy);
    longint dx, dy;
    dx = longint'($signed(a.ox)) - longint'($signed(b.ox)) - sx;
    dy = longint'($signed(a.oy)) - longint'($signed(b.oy)) - sy;
    return rpds_pkg::NEAR_SCALE * (dx * dx + dy * dy)
           < (longint'(1) << (2 * rpds_pkg::OFFSET_FRAC_BITS));
  endfunction

  // settle the pixel above the input and queue its final state
  function automatic void predict_final_state(rpds_pkg::pixel_t cur);
    int unsigned      w, h, r, c, pr;
    rpds_pkg::pixel_t pend, right;
    bit               interior;
    final_t           res;
    w = clamp_dim(frame_width_q, rpds_pkg::MAX_WIDTH_DEF);
    h = clamp_dim(frame_height_q, rpds_pkg::MAX_HEIGHT);
    r = (row_cnt >= h) ? h - 1 : row_cnt;
    c = (col_cnt >= w) ? w - 1 : col_cnt;
    if (r >= 1) begin
      pend = line_store[c];
      pr = r - 1;
      interior = pr >= rpds_pkg::BORDER && pr + rpds_pkg::BORDER < h &&
                 c >= rpds_pkg::BORDER && c + rpds_pkg::BORDER < w;
      if (interior && pend.st != rpds_pkg::ST_NONE && c + 1 < w) begin
        right = line_store[c + 1];
        // right neighbour first, pixel below only if that pair is apart
        if (right.st != rpds_pkg::ST_NONE && is_near(pend, right, ONE_PX, 0)) begin
          if (pend.str < right.str) pend.st = rpds_pkg::ST_NONE;
          else right.st = rpds_pkg::ST_NONE;
        end else if (cur.st != rpds_pkg::ST_NONE && is_near(pend, cur, 0, ONE_PX)) begin
          if (pend.str < cur.str) pend.st = rpds_pkg::ST_NONE;
          else cur.st = rpds_pkg::ST_NONE;
        end
        line_store[c + 1] = right;
      end
      res.st  = pend.st;
      res.row = rpds_pkg::ROW_W'(pr);
      res.col = rpds_pkg::OUT_COL_W'(c);
      final_q.push_back(res);
    end
    line_store[c] = cur;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endfunction

  // candidate pixel; clustered pixels sit near the shared corners of pixel
  // pairs so that right and lower neighbours often fall within 0.2 px
  function automatic rpds_pkg::pixel_t make_pixel(bit clustered);
    rpds_pkg::pixel_t p;
    int               pick;
    pick = $urandom_range(0, 9);
    p.st = (pick == 0) ? rpds_pkg::ST_NONE : (pick == 1) ? ST_SPARE :
           (pick < 6) ? ST_RIDGE : ST_FLAGGED;
    if (!clustered || $urandom_range(0, 9) == 0) begin
      p.ox  = rpds_pkg::OFS_W'($urandom);
      p.oy  = rpds_pkg::OFS_W'($urandom);
      p.str = rpds_pkg::STR_W'($urandom);
    end else begin
      p.ox  = rpds_pkg::OFS_W'(((col_cnt % 2) ? -512 : 511) + $urandom_range(0, 240) - 120);
      p.oy  = rpds_pkg::OFS_W'(((row_cnt % 2) ? -512 : 511) + $urandom_range(0, 240) - 120);
      p.str = $urandom_range(0, 1) ? rpds_pkg::STR_W'($urandom_range(0, 3)) :
                                     rpds_pkg::STR_W'($urandom);
    end
    return p;
  endfunction

  // one input transaction, with a random gap in front
  task automatic send_pixel(rpds_pkg::pixel_t p);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_state <= p.st;
    pix_if.offset_x    <= p.ox;
    pix_if.offset_y    <= p.oy;
    pix_if.strength    <= p.str;
    do @(posedge clk_i); while (!pix_if.ready);
    predict_final_state(p);
    n_pixels++;
  endtask

  task automatic send_random(int count, bit clustered);
    repeat (count) send_pixel(make_pixel(clustered));
  endtask

  // stop input, let every result return and row 0 writes finish
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (final_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both frame size registers back to back; restarts the frame
  task automatic set_frame(logic [rpds_pkg::CFG_W-1:0] w_raw,
                           logic [rpds_pkg::CFG_W-1:0] h_raw);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= rpds_pkg::REG_FRAME_WIDTH;
    cfg_wdata_i <= w_raw;
    @(posedge clk_i);
    cfg_idx_i   <= rpds_pkg::REG_FRAME_HEIGHT;
    cfg_wdata_i <= h_raw;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    frame_width_q  = w_raw[rpds_pkg::FW_W-1:0];
    frame_height_q = h_raw[rpds_pkg::FH_W-1:0];
    row_cnt = 0;
    col_cnt = 0;
    n_writes += 2;
  endtask

  // one 5x5 frame of field extremes with a tied close pair in the interior
  task automatic test_directed_frame();
    rpds_pkg::pixel_t p;
    set_frame(13'd5, 13'd5);
    for (int i = 0; i < 25; i++) begin
      p.st  = rpds_pkg::STATE_W'(i % 4);
      p.ox  = (i % 2) ? -11'sd1024 : 11'sd1023;
      p.oy  = (i % 3) ? 11'sd1023 : -11'sd1024;
      p.str = (i % 2) ? 16'hFFFF : 16'h0000;
      if (i == 12) begin
        p.st = ST_RIDGE; p.ox = 11'sd512; p.oy = 11'sd0; p.str = 16'd100;
      end else if (i == 13) begin
        p.st = ST_FLAGGED; p.ox = -11'sd512; p.oy = 11'sd0; p.str = 16'd100;
      end
      send_pixel(p);
    end
    wait_idle();
  endtask

  // saturated and masked frame sizes, start of the widest line, tallest frame
  task automatic test_frame_limits();
    set_frame(13'd0, 13'd0);
    send_random(60, 1'b1);
    wait_idle();
    // widest line: still in row 0, so no result may come back
    gap_max   = 0;
    stall_max = 2;
    set_frame(13'h1FFF, 13'h1FFF);
    send_random(WIDE_PIXELS, 1'b1);
    wait_idle();
    gap_max   = 13;
    stall_max = 13;
    set_frame(13'h1006, 13'd4096);
    send_random(150, 1'b1);
    wait_idle();
  endtask

  // long output hold-off while input keeps coming at full rate
  task automatic test_output_backpressure();
    set_frame(13'd8, 13'd6);
    gap_max   = 0;
    stall_max = 0;
    hold_req  = 1'b1;
    send_random(200, 1'b1);
    gap_max   = 13;
    stall_max = 13;
    wait_idle();
  endtask

  // random frame sizes and idling patterns, often stopping mid-frame
  task automatic test_random_frames();
    int sent, w, h, count, mode;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      if ($urandom_range(0, 3) != 0) begin
        w = ($urandom_range(0, 3) == 0) ? rpds_pkg::MIN_DIM :
            $urandom_range(rpds_pkg::MIN_DIM, 12);
        h = ($urandom_range(0, 3) == 0) ? rpds_pkg::MIN_DIM :
            $urandom_range(rpds_pkg::MIN_DIM, 9);
        set_frame(rpds_pkg::CFG_W'(w), rpds_pkg::CFG_W'(h));
      end
      mode = $urandom_range(0, 3);
      gap_max   = (mode[0]) ? 13 : 0;
      stall_max = (mode[1]) ? 13 : 0;
      count = $urandom_range(10, 150);
      send_random(count, $urandom_range(0, 4) != 0);
      sent += count;
      wait_idle();
    end
    gap_max   = 13;
    stall_max = 13;
  endtask

  // result side: random stalls, plus the one long hold-off on request
  initial begin : result_sink
    int n;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        n_holds++;
      end
      n = $urandom_range(0, stall_max);
      if (n > 0) begin
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // compare each returned transaction with the oldest expectation
  always @(posedge clk_i) begin : check_final_states
    final_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (final_q.size() == 0) begin
        $error("unexpected result: final_state %0d row %0d col %0d",
               res_if.final_state, res_if.out_row, res_if.out_col);
        n_errors++;
      end else begin
        want = final_q.pop_front();
        n_checked++;
        if (res_if.final_state == rpds_pkg::ST_NONE) n_cleared++;
        if (res_if.final_state !== want.st) begin
          $error("final_state mismatch: expected %0d, actual %0d", want.st,
                 res_if.final_state);
          n_errors++;
        end
        if (res_if.out_row !== want.row) begin
          $error("out_row mismatch: expected %0d, actual %0d", want.row, res_if.out_row);
          n_errors++;
        end
        if (res_if.out_col !== want.col) begin
          $error("out_col mismatch: expected %0d, actual %0d", want.col, res_if.out_col);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      stuck_cnt <= 0;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
    if (stuck_cnt >= STUCK_LIMIT) begin
      $display("ridge_point_duplicate_suppress verification failed");
      $finish;
    end
  end

  // sequence
  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= rpds_pkg::REG_FRAME_WIDTH;
    cfg_wdata_i        <= '0;
    pix_if.valid       <= 1'b0;
    pix_if.pixel_state <= '0;
    pix_if.offset_x    <= '0;
    pix_if.offset_y    <= '0;
    pix_if.strength    <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frame();
    test_frame_limits();
    test_output_backpressure();
    test_random_frames();

    wait_idle();
    $display("run: %0d pixels in, %0d results checked (%0d cleared or empty),",
             n_pixels, n_checked, n_cleared);
    $display("%0d register writes, saturated and small frames, %0d long output hold-off(s)",
             n_writes, n_holds);
    if (n_errors == 0) begin
      $display("ridge_point_duplicate_suppress verification clean");
    end else begin
      $display("ridge_point_duplicate_suppress verification failed");
    end
    $finish;
  end

endmodule
